FILE: hw/rtl/mfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mfs_pkg: shared types and constants of the max flow solver
// Holds the sequencer state type, register indexes and fixed field widths.
// -----------------------------------------------------------------------------
package mfs_pkg;

  localparam int FLOW_W  = 36;
  localparam int NODE_W  = 4;
  localparam int IN_CAP_W = 32;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINK_NODE   = 2'd2;

  typedef enum logic [7:0] {
    ST_LOAD     = 8'b0000_0001,
    ST_COPY     = 8'b0000_0010,
    ST_BFS_INIT = 8'b0000_0100,
    ST_BFS_POP  = 8'b0000_1000,
    ST_BFS_SCAN = 8'b0001_0000,
    ST_AUG_MIN  = 8'b0010_0000,
    ST_AUG_UPD  = 8'b0100_0000,
    ST_EMIT     = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/max_flow_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// max_flow_solver: Edmonds-Karp maximum flow over a dense capacity matrix
// Loads capacity entries one per transfer, solves on the entry marked last and
// returns the total flow from source to sink as one result transfer.
// -----------------------------------------------------------------------------
// A matrix entry is taken every cycle while the solver is loading; no entry is
// taken during a solve. An entry with tlast starts a solve: a copy sweep into
// the residual memory, then a breadth-first search per augmenting path (one
// residual read per scanned neighbor), a walk back along the path to find the
// bottleneck and a second walk to update the residual entries along it.
// Reset: synchronous, active high; registers return to 16 nodes, source 0,
// sink 15, no result pending. Memory contents are not cleared.
// -----------------------------------------------------------------------------
module max_flow_solver #(
  parameter int MAX_NODES = 16,
  parameter int CAP_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [mfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mfs_pkg::CFG_W-1:0]       cfg_data,
  // matrix entry stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // from_node[3:0], to_node[7:4], capacity[39:8]
  input  wire logic        s_axis_tlast,   // last entry, starts the solve
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // max_flow[35:0], zero padding [39:36]
);

  localparam int IW    = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int NW    = $clog2(MAX_NODES + 1);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 2 ** AW;
  localparam int RW    = CAP_WIDTH + 1;
  localparam int FW    = mfs_pkg::FLOW_W;
  localparam int SW    = ((RW > FW) ? RW : FW) + 1;
  localparam int CW    = (CAP_WIDTH < mfs_pkg::IN_CAP_W) ? CAP_WIDTH : mfs_pkg::IN_CAP_W;

  // configuration registers
  logic [4:0] node_count;
  logic [3:0] source_node;
  logic [3:0] sink_node;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= 5'd16;
      source_node <= 4'd0;
      sink_node   <= 4'd15;
    end else if (cfg_we) begin
      case (cfg_index)
        mfs_pkg::REG_NODE_COUNT:  node_count  <= cfg_data;
        mfs_pkg::REG_SOURCE_NODE: source_node <= cfg_data[3:0];
        mfs_pkg::REG_SINK_NODE:   sink_node   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // clamp node count into 2..MAX_NODES
  logic [NW-1:0] n_eff;
  always_comb begin
    if (node_count < 5'd2) begin
      n_eff = NW'(2);
    end else if (int'(node_count) > MAX_NODES) begin
      n_eff = NW'(MAX_NODES);
    end else begin
      n_eff = NW'(node_count);
    end
  end

  logic          degenerate;
  logic [IW-1:0] s_idx;
  logic [IW-1:0] t_idx;
  assign degenerate = (int'(source_node) >= int'(n_eff)) || (int'(sink_node) >= int'(n_eff))
                      || (source_node == sink_node);
  assign s_idx = IW'(source_node);
  assign t_idx = IW'(sink_node);

  // input field split
  logic [3:0]               in_from;
  logic [3:0]               in_to;
  logic [CAP_WIDTH-1:0]     in_cap;
  logic                     in_acc;
  assign in_from = s_axis_tdata[3:0];
  assign in_to   = s_axis_tdata[7:4];
  assign in_cap  = CAP_WIDTH'(s_axis_tdata[8 +: CW]);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // capacity memory: written by the stream, read by the copy sweep
  logic [CAP_WIDTH-1:0] cap_mem [DEPTH];
  logic                 cap_we;
  logic [AW-1:0]        cap_wa;
  logic [AW-1:0]        cap_ra;
  logic [CAP_WIDTH-1:0] cap_rd;

  assign cap_we = in_acc && (int'(in_from) < MAX_NODES) && (int'(in_to) < MAX_NODES);
  assign cap_wa = {IW'(in_from), IW'(in_to)};

  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_mem[cap_wa] <= in_cap;
    end
    cap_rd <= cap_mem[cap_ra];
  end

  // residual memory: one write, one registered read per cycle
  logic [RW-1:0] res_mem [DEPTH];
  logic          res_we;
  logic [AW-1:0] res_wa;
  logic [RW-1:0] res_wd;
  logic [AW-1:0] res_ra;
  logic [RW-1:0] res_rd;

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[res_wa] <= res_wd;
    end
    res_rd <= res_mem[res_ra];
  end

  // search storage: queue and parent links
  logic [IW-1:0] queue  [MAX_NODES];
  logic [IW-1:0] parent [MAX_NODES];
  logic [MAX_NODES-1:0] visited;

  mfs_pkg::state_t state;
  logic [AW:0]     copy_cnt;
  logic [NW-1:0]   head;
  logic [NW-1:0]   tail;
  logic [NW-1:0]   vcnt;
  logic [IW-1:0]   u_node;
  logic [IW-1:0]   v_node;
  logic [NW-1:0]   steps;
  logic [1:0]      phase;
  logic [RW-1:0]   neck;
  logic [FW-1:0]   total;

  logic [NW-1:0]   vm1;
  logic [IW-1:0]   v_scan;
  logic [IW-1:0]   par_v;
  logic            path_end;
  logic [SW-1:0]   sum;
  logic [FW-1:0]   total_next;

  assign vm1      = vcnt - NW'(1);
  assign v_scan   = vm1[IW-1:0];
  assign par_v    = parent[v_node];
  assign path_end = (v_node == s_idx) || (steps == n_eff);
  assign sum      = SW'(total) + SW'(neck);
  assign total_next = (sum > SW'({FW{1'b1}})) ? {FW{1'b1}} : FW'(sum);

  assign s_axis_tready = (state == mfs_pkg::ST_LOAD);

  // memory addressing per state
  always_comb begin
    cap_ra = copy_cnt[AW-1:0];
    res_we = 1'b0;
    res_wa = AW'(copy_cnt - (AW+1)'(1));
    res_wd = RW'(cap_rd);
    res_ra = {u_node, vcnt[IW-1:0]};
    case (state)
      mfs_pkg::ST_COPY: begin
        res_we = (copy_cnt != '0);
      end
      mfs_pkg::ST_AUG_MIN: begin
        res_ra = {par_v, v_node};
      end
      mfs_pkg::ST_AUG_UPD: begin
        res_ra = {par_v, v_node};
        if (phase == 2'd1) begin
          res_we = 1'b1;
          res_wa = {par_v, v_node};
          res_wd = res_rd - neck;
          res_ra = {v_node, par_v};
        end else if (phase == 2'd2) begin
          res_we = 1'b1;
          res_wa = {v_node, u_node};
          res_wd = res_rd + neck;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mfs_pkg::ST_LOAD;
      m_axis_tvalid <= 1'b0;
      visited       <= '0;
      total         <= '0;
    end else begin
      // drop the result once it transfers, unless a new one replaces it
      if (m_axis_tvalid && m_axis_tready && (state != mfs_pkg::ST_EMIT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        mfs_pkg::ST_LOAD: begin
          if (in_acc && s_axis_tlast) begin
            total    <= '0;
            copy_cnt <= '0;
            state    <= degenerate ? mfs_pkg::ST_EMIT : mfs_pkg::ST_COPY;
          end
        end
        mfs_pkg::ST_COPY: begin
          // read one entry, write the previous one
          copy_cnt <= copy_cnt + (AW+1)'(1);
          if (copy_cnt[AW]) begin
            state <= mfs_pkg::ST_BFS_INIT;
          end
        end
        mfs_pkg::ST_BFS_INIT: begin
          visited       <= {{(MAX_NODES-1){1'b0}}, 1'b1} << s_idx;
          queue[0]      <= s_idx;
          head          <= '0;
          tail          <= NW'(1);
          state         <= mfs_pkg::ST_BFS_POP;
        end
        mfs_pkg::ST_BFS_POP: begin
          if (head == tail) begin
            if (visited[t_idx]) begin
              v_node <= t_idx;
              steps  <= '0;
              phase  <= 2'd0;
              neck   <= '1;
              state  <= mfs_pkg::ST_AUG_MIN;
            end else begin
              state <= mfs_pkg::ST_EMIT;
            end
          end else begin
            u_node <= queue[head[IW-1:0]];
            head   <= head + NW'(1);
            vcnt   <= '0;
            state  <= mfs_pkg::ST_BFS_SCAN;
          end
        end
        mfs_pkg::ST_BFS_SCAN: begin
          // read for vcnt issues now, judge vcnt-1 on the returned data
          vcnt <= vcnt + NW'(1);
          if (vcnt != '0) begin
            if (!visited[v_scan] && (res_rd != '0) && (int'(tail) < MAX_NODES)) begin
              queue[tail[IW-1:0]] <= v_scan;
              parent[v_scan]      <= u_node;
              visited[v_scan]     <= 1'b1;
              tail                <= tail + NW'(1);
            end
          end
          if (vcnt == n_eff) begin
            state <= mfs_pkg::ST_BFS_POP;
          end
        end
        mfs_pkg::ST_AUG_MIN: begin
          if (phase == 2'd0) begin
            if (path_end) begin
              v_node <= t_idx;
              steps  <= '0;
              state  <= mfs_pkg::ST_AUG_UPD;
            end else begin
              phase <= 2'd1;
            end
          end else begin
            if (res_rd < neck) begin
              neck <= res_rd;
            end
            v_node <= par_v;
            steps  <= steps + NW'(1);
            phase  <= 2'd0;
          end
        end
        mfs_pkg::ST_AUG_UPD: begin
          case (phase)
            2'd0: begin
              if (path_end) begin
                total <= total_next;
                state <= mfs_pkg::ST_BFS_INIT;
              end else begin
                phase <= 2'd1;
              end
            end
            2'd1: begin
              u_node <= par_v;
              phase  <= 2'd2;
            end
            default: begin
              v_node <= u_node;
              steps  <= steps + NW'(1);
              phase  <= 2'd0;
            end
          endcase
        end
        mfs_pkg::ST_EMIT: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {4'd0, total};
            state         <= mfs_pkg::ST_LOAD;
          end
        end
        default: begin
          state <= mfs_pkg::ST_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
